/* rtl/core/aes128_cbc_encrypt_core_macros.svh */
// Assertion macros for the AES-128 CBC core checker.
// Used by the checker file only; no other dependencies.
`ifndef AES128_CBC_ENCRYPT_CORE_MACROS_SVH
`define AES128_CBC_ENCRYPT_CORE_MACROS_SVH
// implication checked on every rising clock edge, off during reset
`define ACE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ACE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/ace_pkg.sv */
// Package for the AES-128 CBC core: types, codes, S-box and round helpers.
// No dependencies.
`default_nettype none
package ace_pkg;
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_IV_LOW   = 2'd3;
    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef logic [127:0] t_block;
    typedef logic [31:0]  t_word;

    // controller -> datapath
    typedef struct packed {
        logic       key_start;   // load key words, begin expansion
        logic       key_step;    // compute one more round key
        logic       blk_load;    // pad, whiten, add round key 0
        logic       blk_round;   // one full round
        logic       blk_last;    // final round, update chain
        logic [3:0] round;       // round number for key select
    } t_cmd;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // round constant for round r (1..10)
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] c;
        c = 8'h01;
        for (int i = 1; i < 10; i++) begin
            if (i < int'(r)) c = xtime(c);
        end
        return c;
    endfunction

    // byte b of a block, byte 0 in the top bits
    function automatic logic [7:0] byte_of(input t_block s, input int b);
        return s[127-8*b -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(c*4+r) -: 8] = sbox(byte_of(s, ((c + r) % 4) * 4 + r));
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_of(s, c*4);
            a1 = byte_of(s, c*4+1);
            a2 = byte_of(s, c*4+2);
            a3 = byte_of(s, c*4+3);
            t[127-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111-32*c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103-32*c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/ace_if.sv */
// Valid/ready channel interfaces for the AES-128 CBC core.
// No dependencies.
`default_nettype none
interface ace_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  valid_bytes;
    logic        chain_start;
    modport source (output valid, block_high, block_low, valid_bytes, chain_start,
                    input ready);
    modport sink   (input valid, block_high, block_low, valid_bytes, chain_start,
                    output ready);
endinterface

interface ace_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    modport source (output valid, cipher_high, cipher_low, input ready);
    modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

interface ace_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/ace_datapath.sv */
// AES datapath: key/IV registers, round key memory, state and chain registers.
// Depends on ace_pkg.
`default_nettype none
module ace_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [63:0]   i_cfg_data,
    input  wire ace_pkg::t_cmd i_cmd,
    input  wire logic [63:0]   i_block_high,
    input  wire logic [63:0]   i_block_low,
    input  wire logic [4:0]    i_valid_bytes,
    input  wire logic          i_chain_start,
    output      logic [127:0]  o_cipher
);
    import ace_pkg::*;

    logic [63:0] r_key_high, r_key_low, r_iv_high, r_iv_low;
    t_block      r_chain, r_state, r_rkey;
    t_block      r_rk [11];
    t_block      n_rkey, n_state, pad, round_out, blk_in;
    t_word       rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0; r_key_low <= '0; r_iv_high <= '0; r_iv_low <= '0;
            r_chain <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_HIGH: r_key_high <= i_cfg_data;
                    REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    REG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                    REG_IV_LOW:   r_iv_low   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.blk_last) r_chain <= round_out;
        end
    end

    // key schedule: one round key (four words) per step
    always_comb begin
        rot = {r_rkey[23:0], r_rkey[31:24]};
        n_rkey[127:96] = r_rkey[127:96] ^ {sbox(rot[31:24]) ^ rcon(i_cmd.round),
            sbox(rot[23:16]), sbox(rot[15:8]), sbox(rot[7:0])};
        n_rkey[95:64] = r_rkey[95:64] ^ n_rkey[127:96];
        n_rkey[63:32] = r_rkey[63:32] ^ n_rkey[95:64];
        n_rkey[31:0]  = r_rkey[31:0]  ^ n_rkey[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_start) begin
            r_rkey <= {r_key_high, r_key_low};
            r_rk[0] <= {r_key_high, r_key_low};
        end else if (i_cmd.key_step) begin
            r_rkey <= n_rkey;
            r_rk[i_cmd.round] <= n_rkey;
        end
    end

    always_comb begin
        blk_in = {i_block_high, i_block_low};
        for (int b = 0; b < 16; b++) begin
            pad[127-8*b -: 8] = (5'(b) < i_valid_bytes) ? blk_in[127-8*b -: 8] : 8'h00;
        end
        round_out = sub_shift(r_state);
        if (!i_cmd.blk_last) round_out = mix_columns(round_out);
        round_out = round_out ^ r_rk[i_cmd.round];
        n_state = r_state;
        if (i_cmd.blk_load)
            n_state = pad ^ (i_chain_start ? {r_iv_high, r_iv_low} : r_chain) ^ r_rk[0];
        else if (i_cmd.blk_round || i_cmd.blk_last)
            n_state = round_out;
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_cipher = r_chain;
endmodule
`default_nettype wire

/* rtl/core/ace_ctrl.sv */
// Controller FSM: key expansion sequence, round sequence, handshakes.
// Depends on ace_pkg.
`default_nettype none
module ace_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_key_written,
    input  wire logic          i_in_valid,
    output      logic          o_in_ready,
    output      logic          o_out_valid,
    input  wire logic          i_out_ready,
    output      ace_pkg::t_cmd o_cmd
);
    import ace_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEY  = 2'd1;
    localparam logic [1:0] ST_ENC  = 2'd2;

    logic [1:0] r_st, n_st;
    logic [3:0] r_rnd, n_rnd;
    logic       r_ov, n_ov;
    logic       r_kpend, n_kpend;

    always_comb begin
        n_st = r_st; n_rnd = r_rnd; n_ov = r_ov; n_kpend = r_kpend | i_key_written;
        o_cmd = '0;
        o_cmd.round = r_rnd;
        o_in_ready = 1'b0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (r_kpend) begin
                    o_cmd.key_start = 1'b1;
                    n_kpend = i_key_written;
                    n_rnd = 4'd1;
                    n_st = ST_KEY;
                end else begin
                    // a new word enters once the output slot will be free
                    o_in_ready = !r_ov || i_out_ready;
                    if (i_in_valid && o_in_ready) begin
                        o_cmd.blk_load = 1'b1;
                        n_rnd = 4'd1;
                        n_st = ST_ENC;
                    end
                end
            end
            ST_KEY: begin
                o_cmd.key_step = 1'b1;
                n_rnd = r_rnd + 4'd1;
                if (r_rnd == 4'd10) n_st = ST_IDLE;
            end
            ST_ENC: begin
                n_rnd = r_rnd + 4'd1;
                if (r_rnd == 4'd10) begin
                    o_cmd.blk_last = 1'b1;
                    n_ov = 1'b1;
                    n_st = ST_IDLE;
                end else begin
                    o_cmd.blk_round = 1'b1;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_rnd <= '0; r_ov <= 1'b0; r_kpend <= 1'b0;
        end else begin
            r_st <= n_st; r_rnd <= n_rnd; r_ov <= n_ov; r_kpend <= n_kpend;
        end
    end

    assign o_out_valid = r_ov;
endmodule
`default_nettype wire

/* rtl/core/aes128_cbc_encrypt_core.sv */
// AES-128 CBC encryption core, top level: controller plus datapath.
// Depends on ace_pkg, ace_if, ace_ctrl, ace_datapath.
// Each input word is zero-padded past valid_bytes, XORed with the IV (chain_start)
// or the previous ciphertext, and encrypted with one AES round per cycle: load,
// nine full rounds, final round, then the result sits in the output register while
// the next word may enter. The round loop through the single state register means
// a new word is taken only after the last one has finished its final round.
// Writing either key register expands the round keys, during which no input word is
// taken. The output is one ciphertext word per input word.
`default_nettype none
module aes128_cbc_encrypt_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ace_cfg_if.sink   cfg,
    ace_in_if.sink    in_ch,
    ace_out_if.source out_ch
);
    import ace_pkg::*;

    t_cmd         cmd;
    logic [127:0] cipher;
    logic         key_wr;

    assign cfg.ready = 1'b1;
    // a write to either key half triggers re-expansion
    assign key_wr = cfg.valid && (cfg.index == REG_KEY_HIGH || cfg.index == REG_KEY_LOW);

    ace_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_key_written (key_wr),
        .i_in_valid    (in_ch.valid),
        .o_in_ready    (in_ch.ready),
        .o_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .o_cmd         (cmd)
    );

    ace_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cfg_we      (cfg.valid),
        .i_cfg_idx     (cfg.index),
        .i_cfg_data    (cfg.data),
        .i_cmd         (cmd),
        .i_block_high  (in_ch.block_high),
        .i_block_low   (in_ch.block_low),
        .i_valid_bytes (in_ch.valid_bytes),
        .i_chain_start (in_ch.chain_start),
        .o_cipher      (cipher)
    );

    assign out_ch.cipher_high = cipher[127:64];
    assign out_ch.cipher_low  = cipher[63:0];
endmodule
`default_nettype wire

/* rtl/core/ace_checker.sv */
// Port-level checker for the AES-128 CBC core, bound to the top level.
// Depends on aes128_cbc_encrypt_core_macros.svh.
`default_nettype none
`include "aes128_cbc_encrypt_core_macros.svh"
module ace_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_cipher_high
);
    // an accepted word never yields a result in the next cycle
    `ACE_ASSERT_NXT(a_no_early, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid))
    // no input taken while the core is computing a block
    `ACE_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // a pending result holds while stalled
    `ACE_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_cipher_high))
endmodule

bind aes128_cbc_encrypt_core ace_checker u_ace_checker (
    .i_clk, .i_rst_n,
    .i_in_valid    (in_ch.valid),
    .i_in_ready    (in_ch.ready),
    .i_out_valid   (out_ch.valid),
    .i_out_ready   (out_ch.ready),
    .i_cipher_high (out_ch.cipher_high)
);
`default_nettype wire
